// ===== design/dock_keyboard_scan_decoder_assert.svh =====
// Assertion macros shared by the dock keyboard decoder modules.
// Each macro checks one implication on the rising clock edge while reset is released.
`ifndef DOCK_KEYBOARD_SCAN_DECODER_ASSERT_SVH
`define DOCK_KEYBOARD_SCAN_DECODER_ASSERT_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define DKBD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dock keyboard decoder: assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define DKBD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dock keyboard decoder: assertion failed");
`else
`define DKBD_ASSERT_IMP(label, clk, rstn, ante, cons)
`define DKBD_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== design/dkbd_pkg.sv =====
package dkbd_pkg;

    // Key map size and key index widths.
    localparam int NUM_KEYS  = 128;
    localparam int KEY_W     = 7;
    localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Result queue.
    localparam int MAX_RESULTS = 2;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    // Fixed byte codes and time limits.
    localparam logic [7:0]  CAPS_ON_ECHO      = 8'hca;
    localparam logic [7:0]  CAPS_OFF_ECHO     = 8'hcb;
    localparam logic [15:0] RESTORE_WINDOW_MS = 16'd1000;
    localparam logic [15:0] MS_MAX            = 16'hffff;

    // Configuration reset values.
    localparam logic [7:0]       US_CODE_RST   = 8'd0;
    localparam logic [7:0]       UK_CODE_RST   = 8'd1;
    localparam logic [15:0]      HS_DELAY_RST  = 16'd500;
    localparam logic [15:0]      HOLD_MS_RST   = 16'd333;
    localparam logic [KEY_W-1:0] PREV_KEY_RST  = 7'h45;
    localparam logic [KEY_W-1:0] NEXT_KEY_RST  = 7'h48;
    localparam logic [KEY_W-1:0] LOW_KEY_RST   = 7'd0;
    localparam logic [KEY_W-1:0] HIGH_KEY_RST  = 7'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_US_CODE  = 3'd0,
        CFG_UK_CODE  = 3'd1,
        CFG_HS_DELAY = 3'd2,
        CFG_HOLD_MS  = 3'd3,
        CFG_PREV_KEY = 3'd4,
        CFG_NEXT_KEY = 3'd5,
        CFG_LOW_KEY  = 3'd6,
        CFG_HIGH_KEY = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_SCAN       = 2'd0,
        KIND_TICK       = 2'd1,
        KIND_CONNECT    = 2'd2,
        KIND_DISCONNECT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        LAYOUT_UNKNOWN = 2'd0,
        LAYOUT_US      = 2'd1,
        LAYOUT_UK      = 2'd2
    } layout_t;

    typedef enum logic [2:0] {
        EV_KEY_CHANGE  = 3'd0,
        EV_US_LAYOUT   = 3'd1,
        EV_UK_LAYOUT   = 3'd2,
        EV_NEXT_TRACK  = 3'd3,
        EV_PREV_TRACK  = 3'd4,
        EV_RELEASE_ALL = 3'd5
    } event_t;

    typedef struct packed {
        logic [7:0]       us_code;
        logic [7:0]       uk_code;
        logic [15:0]      hs_delay;
        logic [15:0]      hold_ms;
        logic [KEY_W-1:0] prev_key;
        logic [KEY_W-1:0] next_key;
        logic [KEY_W-1:0] low_key;
        logic [KEY_W-1:0] high_key;
    } cfg_t;

    typedef struct packed {
        event_t           ev;
        logic [KEY_W-1:0] key;
        logic             pressed;
        logic             last;
    } result_t;

    // Builds one result word with the last flag cleared.
    function automatic result_t make_res(event_t ev, logic [KEY_W-1:0] key, logic pressed);
        result_t r;
        r.ev      = ev;
        r.key     = key;
        r.pressed = pressed;
        r.last    = 1'b0;
        return r;
    endfunction

endpackage

// ===== design/dkbd_cfg_regs.sv =====
module dkbd_cfg_regs
    import dkbd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register write decode.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_US_CODE:  cfg_next.us_code  = cfg_data[7:0];
                CFG_UK_CODE:  cfg_next.uk_code  = cfg_data[7:0];
                CFG_HS_DELAY: cfg_next.hs_delay = cfg_data[15:0];
                CFG_HOLD_MS:  cfg_next.hold_ms  = cfg_data[15:0];
                CFG_PREV_KEY: cfg_next.prev_key = cfg_data[KEY_W-1:0];
                CFG_NEXT_KEY: cfg_next.next_key = cfg_data[KEY_W-1:0];
                CFG_LOW_KEY:  cfg_next.low_key  = cfg_data[KEY_W-1:0];
                CFG_HIGH_KEY: cfg_next.high_key = cfg_data[KEY_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.us_code  <= US_CODE_RST;
            cfg_reg.uk_code  <= UK_CODE_RST;
            cfg_reg.hs_delay <= HS_DELAY_RST;
            cfg_reg.hold_ms  <= HOLD_MS_RST;
            cfg_reg.prev_key <= PREV_KEY_RST;
            cfg_reg.next_key <= NEXT_KEY_RST;
            cfg_reg.low_key  <= LOW_KEY_RST;
            cfg_reg.high_key <= HIGH_KEY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/dkbd_core.sv =====
`include "dock_keyboard_scan_decoder_assert.svh"

module dkbd_core
    import dkbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  kind_t      kind,
    input  logic [7:0] scan_byte,
    input  cfg_t       cfg,
    output logic [1:0] res_cnt,
    output result_t    res0,
    output result_t    res1
);

    layout_t              layout_reg, layout_next;
    layout_t              saved_layout_reg, saved_layout_next;
    logic                 hs_done_reg, hs_done_next;
    logic [15:0]          ms_conn_reg, ms_conn_next;
    logic [15:0]          ms_disc_reg, ms_disc_next;
    logic [NUM_KEYS-1:0]  key_down_reg, key_down_next;
    logic                 long_hold_reg, long_hold_next;
    logic                 hold_run_reg, hold_run_next;
    logic [15:0]          hold_cnt_reg, hold_cnt_next;
    logic [KEY_W-1:0]     held_key_reg, held_key_next;

    // A key index is valid for the map only below the map size.
    function automatic logic key_in_map(logic [KEY_W-1:0] key);
        return {1'b0, key} < (KEY_W + 1)'(NUM_KEYS);
    endfunction

    function automatic logic key_is_down(logic [NUM_KEYS-1:0] map, logic [KEY_W-1:0] key);
        return key_in_map(key) && map[key[KEY_IDX_W-1:0]];
    endfunction

    // State update and result generation for one item.
    always_comb begin
        logic             press;
        logic [KEY_W-1:0] key;
        logic             first_v, second_v;
        result_t          first_r, second_r;
        event_t           media_ev;

        layout_next       = layout_reg;
        saved_layout_next = saved_layout_reg;
        hs_done_next      = hs_done_reg;
        ms_conn_next      = ms_conn_reg;
        ms_disc_next      = ms_disc_reg;
        key_down_next     = key_down_reg;
        long_hold_next    = long_hold_reg;
        hold_run_next     = hold_run_reg;
        hold_cnt_next     = hold_cnt_reg;
        held_key_next     = held_key_reg;

        press    = ~scan_byte[7];
        key      = scan_byte[KEY_W-1:0];
        first_v  = 1'b0;
        second_v = 1'b0;
        first_r  = make_res(EV_KEY_CHANGE, '0, 1'b0);
        second_r = make_res(EV_KEY_CHANGE, '0, 1'b0);
        media_ev = (held_key_reg == cfg.next_key) ? EV_NEXT_TRACK : EV_PREV_TRACK;

        if (fire) begin
            case (kind)
                KIND_SCAN: begin
                    if (layout_reg == LAYOUT_UNKNOWN) begin
                        // The first byte matching a layout code sets the layout.
                        if (scan_byte == cfg.us_code) begin
                            layout_next = LAYOUT_US;
                            second_v    = 1'b1;
                            second_r    = make_res(EV_US_LAYOUT, '0, 1'b0);
                        end else if (scan_byte == cfg.uk_code) begin
                            layout_next = LAYOUT_UK;
                            second_v    = 1'b1;
                            second_r    = make_res(EV_UK_LAYOUT, '0, 1'b0);
                        end
                    end else if (!hs_done_reg) begin
                        // Bytes are dropped until the handshake delay is seen to pass.
                        if (ms_conn_reg >= cfg.hs_delay) begin
                            hs_done_next = 1'b1;
                        end
                    end else if (scan_byte != CAPS_ON_ECHO && scan_byte != CAPS_OFF_ECHO &&
                                 key >= cfg.low_key && key <= cfg.high_key &&
                                 key_in_map(key)) begin
                        // Repair a repeated press or a stray release first.
                        if (press && key_down_reg[key[KEY_IDX_W-1:0]]) begin
                            first_v = 1'b1;
                            first_r = make_res(EV_KEY_CHANGE, key, 1'b0);
                        end else if (!press && !key_down_reg[key[KEY_IDX_W-1:0]]) begin
                            first_v = 1'b1;
                            first_r = make_res(EV_KEY_CHANGE, key, 1'b1);
                        end
                        key_down_next[key[KEY_IDX_W-1:0]] = press;
                        if (key == cfg.prev_key || key == cfg.next_key) begin
                            if (press) begin
                                held_key_next = key;
                                hold_run_next = 1'b1;
                                hold_cnt_next = cfg.hold_ms;
                            end else if (long_hold_reg) begin
                                long_hold_next = 1'b0;
                                second_v       = 1'b1;
                                second_r       = make_res(EV_KEY_CHANGE, key, 1'b0);
                            end
                        end else begin
                            second_v = 1'b1;
                            second_r = make_res(EV_KEY_CHANGE, key, press);
                        end
                    end
                end
                KIND_TICK: begin
                    if (ms_conn_reg != MS_MAX) begin
                        ms_conn_next = ms_conn_reg + 16'd1;
                    end
                    if (ms_disc_reg != MS_MAX) begin
                        ms_disc_next = ms_disc_reg + 16'd1;
                    end
                    // Hold timer: counts down and fires on the tick that reaches zero.
                    if (hold_run_reg) begin
                        if (hold_cnt_reg > 16'd1) begin
                            hold_cnt_next = hold_cnt_reg - 16'd1;
                        end else begin
                            hold_cnt_next = '0;
                            hold_run_next = 1'b0;
                            if (key_is_down(key_down_reg, cfg.prev_key) ||
                                key_is_down(key_down_reg, cfg.next_key)) begin
                                long_hold_next = 1'b1;
                                second_v       = 1'b1;
                                second_r       = make_res(EV_KEY_CHANGE, held_key_reg, 1'b1);
                            end else begin
                                long_hold_next = 1'b0;
                                first_v        = 1'b1;
                                first_r        = make_res(media_ev, '0, 1'b1);
                                second_v       = 1'b1;
                                second_r       = make_res(media_ev, '0, 1'b0);
                            end
                        end
                    end
                end
                KIND_CONNECT: begin
                    ms_conn_next = '0;
                    if (ms_disc_reg < RESTORE_WINDOW_MS) begin
                        layout_next = saved_layout_reg;
                    end
                end
                KIND_DISCONNECT: begin
                    saved_layout_next = layout_reg;
                    layout_next       = LAYOUT_UNKNOWN;
                    hs_done_next      = 1'b0;
                    ms_disc_next      = '0;
                    key_down_next     = '0;
                    if (|key_down_reg) begin
                        second_v = 1'b1;
                        second_r = make_res(EV_RELEASE_ALL, '0, 1'b0);
                    end
                end
                default: begin
                    layout_next = layout_reg;
                end
            endcase
        end

        // Pack the results in order and mark the final one.
        if (first_v) begin
            res0    = first_r;
            res1    = second_r;
            res_cnt = second_v ? 2'd2 : 2'd1;
        end else begin
            res0    = second_r;
            res1    = second_r;
            res_cnt = second_v ? 2'd1 : 2'd0;
        end
        res0.last = (res_cnt == 2'd1);
        res1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layout_reg       <= LAYOUT_UNKNOWN;
            saved_layout_reg <= LAYOUT_UNKNOWN;
            hs_done_reg      <= 1'b0;
            ms_conn_reg      <= '0;
            ms_disc_reg      <= MS_MAX;
            key_down_reg     <= '0;
            long_hold_reg    <= 1'b0;
            hold_run_reg     <= 1'b0;
            hold_cnt_reg     <= '0;
            held_key_reg     <= '0;
        end else begin
            layout_reg       <= layout_next;
            saved_layout_reg <= saved_layout_next;
            hs_done_reg      <= hs_done_next;
            ms_conn_reg      <= ms_conn_next;
            ms_disc_reg      <= ms_disc_next;
            key_down_reg     <= key_down_next;
            long_hold_reg    <= long_hold_next;
            hold_run_reg     <= hold_run_next;
            hold_cnt_reg     <= hold_cnt_next;
            held_key_reg     <= held_key_next;
        end
    end

    // A disconnect leaves no layout, no handshake and no key down.
    `DKBD_ASSERT_NXT(a_disc_clears, aclk, aresetn, fire && kind == KIND_DISCONNECT, layout_reg == LAYOUT_UNKNOWN && !hs_done_reg && key_down_reg == '0)

endmodule

// ===== design/dkbd_out_queue.sv =====
`include "dock_keyboard_scan_decoder_assert.svh"

module dkbd_out_queue
    import dkbd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         push_n,
    input  result_t            push0,
    input  result_t            push1,
    output logic [Q_CNT_W-1:0] free_cnt,
    output logic               out_valid,
    input  logic               out_ready,
    output result_t            out_res
);

    result_t            mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               pop;
    logic [Q_PTR_W-1:0] wr_ptr_plus1;

    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + Q_PTR_W'(1);

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
        cnt_next    = cnt_reg + Q_CNT_W'(push_n) - Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Result word storage; up to two words are written per cycle.
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push1;
        end
    end

    assign out_valid = (cnt_reg != '0);
    assign out_res   = mem_reg[rd_ptr_reg];
    assign free_cnt  = Q_CNT_W'(Q_DEPTH) - cnt_reg;

    // The queue never holds more words than it has room for.
    `DKBD_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= Q_CNT_W'(Q_DEPTH))
    // A push never writes over words not yet taken.
    `DKBD_ASSERT_IMP(a_push_fits, aclk, aresetn, push_n != 2'd0, Q_CNT_W'(push_n) <= free_cnt)

endmodule

// ===== design/dock_keyboard_scan_decoder.sv =====
// Dock keyboard scan decoder. Each input word (scan byte, millisecond tick, connect or
// disconnect) is taken into an input register, decoded against the layout,
// handshake, key map and hold timer state, and its zero, one or two result words are
// written into a four-word result queue; the first result word is valid on the m_ side
// once the input register has passed the word to the core and the queue has stored its
// results. A new input word can be accepted every clock
// as long as the queue has room for two more words, so the sustained rate is one input
// word per clock, limited only by the output side taking one result word per clock.
// Configuration writes take effect at the next clock and should be made while idle.
module dock_keyboard_scan_decoder
    import dkbd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] scan_byte
    input  logic [1:0]            s_tuser,   // [1:0] kind
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [6:0] key_index, [7] pressed
    output logic [2:0]            m_tuser,   // [2:0] event_res
    output logic                  m_tlast
);

    cfg_t               cfg;
    logic               stage_valid_reg, stage_valid_next;
    kind_t              stage_kind_reg;
    logic [7:0]         stage_byte_reg;
    logic               stage_fire;
    logic               s_accept;
    logic [1:0]         res_cnt;
    result_t            res0, res1;
    logic [Q_CNT_W-1:0] q_free;
    result_t            q_head;

    dkbd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register: the held word is decoded once the queue has room for its results.
    assign stage_fire = stage_valid_reg && (q_free >= Q_CNT_W'(MAX_RESULTS));
    assign s_tready   = !stage_valid_reg || stage_fire;
    assign s_accept   = s_tvalid && s_tready;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (s_accept) begin
            stage_valid_next = 1'b1;
        end else if (stage_fire) begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            stage_kind_reg <= kind_t'(s_tuser);
            stage_byte_reg <= s_tdata;
        end
    end

    dkbd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (stage_fire),
        .kind      (stage_kind_reg),
        .scan_byte (stage_byte_reg),
        .cfg       (cfg),
        .res_cnt   (res_cnt),
        .res0      (res0),
        .res1      (res1)
    );

    dkbd_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (res_cnt),
        .push0     (res0),
        .push1     (res1),
        .free_cnt  (q_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (q_head)
    );

    // Result word packing.
    assign m_tdata = {q_head.pressed, q_head.key};
    assign m_tuser = q_head.ev;
    assign m_tlast = q_head.last;

endmodule
